// File: rtl/multiplexed_channel_deframer_assert.svh
// ---------------------------------------------------------------------------
// multiplexed channel deframer assertion macros
// shared property templates for the checker
// ---------------------------------------------------------------------------
`ifndef MULTIPLEXED_CHANNEL_DEFRAMER_ASSERT_SVH
`define MULTIPLEXED_CHANNEL_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define MCD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mcd assertion failed");

// next-cycle implication
`define MCD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mcd assertion failed");

`endif

// File: rtl/mcd_pkg.sv
// ---------------------------------------------------------------------------
// mcd_pkg
// shared types and constants of the multiplexed channel deframer
// ---------------------------------------------------------------------------
package mcd_pkg;

  localparam int unsigned CHANNELS_DEF = 64;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned CHAN_W       = 7;
  localparam int unsigned SLOT_W       = 7;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned MASK_W       = 64;
  localparam int unsigned MASK_IDX_W   = 6;
  localparam int unsigned OUT_TDATA_W  = 24;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 64;

  localparam logic [WORD_W-1:0] MARKER_WORD   = 16'h0000;
  localparam logic [WORD_W-1:0] SAMPLE_OFFSET = 16'h8000;

  typedef enum logic [STATUS_W-1:0] {
    ST_SAMPLE  = 2'd0,
    ST_OVERRUN = 2'd1,
    ST_BADLEN  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_FIRST = 4'b0010,
    PH_RUN   = 4'b0100,
    PH_HALT  = 4'b1000
  } phase_e;

  typedef enum logic {
    REG_CHANNEL_MASK = 1'b0,
    REG_UPPER_BANK   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [MASK_W-1:0] channel_mask;
    logic              upper_bank;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    status_e                    status;
  } result_t;

endpackage

// File: rtl/mcd_cfg.sv
// ---------------------------------------------------------------------------
// mcd_cfg
// apb register file holding channel mask and bank select
// ---------------------------------------------------------------------------
module mcd_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mcd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mcd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output mcd_pkg::cfg_t                       cfg_o
);

  logic [mcd_pkg::MASK_W-1:0] mask_q, mask_d;
  logic                       bank_q, bank_d;
  logic                       wr_en;
  mcd_pkg::reg_e              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = mcd_pkg::reg_e'(paddr[mcd_pkg::APB_ADDR_W-1]);

  always_comb begin
    mask_d = mask_q;
    bank_d = bank_q;
    if (wr_en) begin
      case (reg_sel)
        mcd_pkg::REG_CHANNEL_MASK: mask_d = pwdata[mcd_pkg::MASK_W-1:0];
        mcd_pkg::REG_UPPER_BANK:   bank_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
      bank_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      bank_q <= bank_d;
    end
  end

  always_comb begin
    case (reg_sel)
      mcd_pkg::REG_CHANNEL_MASK: prdata = mask_q;
      mcd_pkg::REG_UPPER_BANK:   prdata = {{(mcd_pkg::APB_DATA_W-1){1'b0}}, bank_q};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.channel_mask = mask_q;
  assign cfg_o.upper_bank   = bank_q;

endmodule

// File: rtl/mcd_in_reg.sv
// ---------------------------------------------------------------------------
// mcd_in_reg
// input register stage for acquisition words
// ---------------------------------------------------------------------------
module mcd_in_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mcd_pkg::WORD_W-1:0]   s_axis_tdata,
  input  logic                         advance_i,
  output logic                         valid_o,
  output logic [mcd_pkg::WORD_W-1:0]   word_o
);

  logic                       valid_q, valid_d;
  logic [mcd_pkg::WORD_W-1:0] word_q, word_d;
  logic                       take;

  assign s_axis_tready = !valid_q || advance_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (take) begin
      valid_d = 1'b1;
      word_d  = s_axis_tdata;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// File: rtl/mcd_core.sv
// ---------------------------------------------------------------------------
// mcd_core
// framing state machine, slot counter and result formation
// ---------------------------------------------------------------------------
module mcd_core #(
  parameter int unsigned CHANNELS = mcd_pkg::CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [mcd_pkg::WORD_W-1:0]   word_i,
  input  mcd_pkg::cfg_t                cfg_i,
  input  logic                         out_free_i,
  output logic                         advance_o,
  output logic                         res_valid_o,
  output mcd_pkg::result_t             res_o
);

  localparam logic [mcd_pkg::SLOT_W-1:0] FULL_SLOTS = mcd_pkg::SLOT_W'(CHANNELS);

  mcd_pkg::phase_e             phase_q, phase_d;
  logic [mcd_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic                        marker_q, marker_d;

  logic                        fire;
  logic                        is_marker;
  logic [mcd_pkg::SLOT_W-1:0]  slot_sel;
  logic [mcd_pkg::SLOT_W-1:0]  want_slot;
  logic                        slot_enabled;
  mcd_pkg::result_t            sample_res;
  mcd_pkg::result_t            err_res;

  assign advance_o = valid_i && out_free_i;
  assign fire      = advance_o;
  assign is_marker = (word_i == mcd_pkg::MARKER_WORD);

  // first word after the opening marker always sits in slot zero
  assign slot_sel     = (phase_q == mcd_pkg::PH_FIRST) ? '0 : slot_q;
  assign slot_enabled = (slot_sel < FULL_SLOTS)
                     && cfg_i.channel_mask[slot_sel[mcd_pkg::MASK_IDX_W-1:0]];
  assign want_slot    = marker_q ? '0 : FULL_SLOTS;

  assign sample_res.sample  = word_i ^ mcd_pkg::SAMPLE_OFFSET;
  assign sample_res.channel = slot_sel + (cfg_i.upper_bank ? FULL_SLOTS : '0);
  assign sample_res.status  = mcd_pkg::ST_SAMPLE;

  always_comb begin
    phase_d     = phase_q;
    slot_d      = slot_q;
    marker_d    = marker_q;
    res_valid_o = 1'b0;
    err_res     = '{sample: '0, channel: '0, status: mcd_pkg::ST_OVERRUN};
    res_o       = sample_res;
    if (fire) begin
      case (phase_q)
        mcd_pkg::PH_HUNT: begin
          if (is_marker) begin
            phase_d = mcd_pkg::PH_FIRST;
          end
        end
        mcd_pkg::PH_FIRST: begin
          phase_d  = mcd_pkg::PH_RUN;
          marker_d = 1'b0;
          if (is_marker) begin
            slot_d = '0;
          end else begin
            slot_d      = mcd_pkg::SLOT_W'(1);
            res_valid_o = slot_enabled;
          end
        end
        mcd_pkg::PH_RUN: begin
          if (!is_marker && slot_q == FULL_SLOTS) begin
            phase_d     = mcd_pkg::PH_HALT;
            res_valid_o = 1'b1;
            res_o       = err_res;
          end else if (is_marker) begin
            if (slot_q != want_slot) begin
              phase_d        = mcd_pkg::PH_HALT;
              res_valid_o    = 1'b1;
              err_res.status = mcd_pkg::ST_BADLEN;
              res_o          = err_res;
            end else begin
              marker_d = 1'b1;
              slot_d   = '0;
            end
          end else begin
            marker_d    = 1'b0;
            slot_d      = slot_q + mcd_pkg::SLOT_W'(1);
            res_valid_o = slot_enabled;
          end
        end
        mcd_pkg::PH_HALT: ;
        default: phase_d = mcd_pkg::PH_HALT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mcd_pkg::PH_HUNT;
      slot_q   <= '0;
      marker_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      slot_q   <= slot_d;
      marker_q <= marker_d;
    end
  end

endmodule

// File: rtl/mcd_out_reg.sv
// ---------------------------------------------------------------------------
// mcd_out_reg
// result register driving the master stream side
// ---------------------------------------------------------------------------
module mcd_out_reg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  mcd_pkg::result_t                  res_i,
  output logic                              free_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [mcd_pkg::STATUS_W-1:0]      m_axis_tuser
);

  logic             valid_q, valid_d;
  mcd_pkg::result_t res_q, res_d;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {
    {(mcd_pkg::OUT_TDATA_W - mcd_pkg::CHAN_W - mcd_pkg::SAMPLE_W){1'b0}},
    res_q.channel, res_q.sample};
  assign m_axis_tuser  = res_q.status;

endmodule

// File: rtl/multiplexed_channel_deframer.sv
// ---------------------------------------------------------------------------
// multiplexed_channel_deframer
// splits a marker-framed stream of offset-binary words into channel samples
// ---------------------------------------------------------------------------
//  port group   dir  payload
//  s_axis       in   tdata[15:0] raw_word
//  m_axis       out  tdata[15:0] sample, tdata[22:16] channel, tuser[1:0] status
//  apb          in   0x0 channel_mask (64 bit), 0x8 upper_bank (1 bit)
//
//  one word per cycle sustained while m_axis does not stall; a taken word
//  reaches m_axis through the input register, then the result register
//  reset clears the framing state, mask to all ones and bank select to zero
//  a stalled m_axis side holds one result and one word, then deasserts tready
//  after a framing error no further results appear until reset
// ---------------------------------------------------------------------------
module multiplexed_channel_deframer #(
  parameter int unsigned CHANNELS = mcd_pkg::CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mcd_pkg::WORD_W-1:0]        s_axis_tdata,   // raw_word
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // sample, channel
  output logic [mcd_pkg::STATUS_W-1:0]      m_axis_tuser,   // status
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mcd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mcd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  mcd_pkg::cfg_t              cfg;
  mcd_pkg::result_t           res;
  logic                       word_valid;
  logic [mcd_pkg::WORD_W-1:0] word;
  logic                       advance;
  logic                       out_free;
  logic                       res_valid;

  mcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcd_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .valid_o       (word_valid),
    .word_o        (word)
  );

  mcd_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (word_valid),
    .word_i      (word),
    .cfg_i       (cfg),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mcd_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_valid),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: rtl/mcd_checker.sv
// ---------------------------------------------------------------------------
// mcd_checker
// port-level properties of the deframer, bound to the top level
// ---------------------------------------------------------------------------
`include "multiplexed_channel_deframer_assert.svh"

module mcd_checker #(
  parameter int unsigned CHANNELS = mcd_pkg::CHANNELS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [mcd_pkg::STATUS_W-1:0]      m_axis_tuser
);

  localparam logic [mcd_pkg::CHAN_W:0] CHAN_LIMIT = (mcd_pkg::CHAN_W + 1)'(2 * CHANNELS);

  logic                        is_error;
  logic [mcd_pkg::CHAN_W:0]    chan_ext;

  assign is_error = m_axis_tuser != mcd_pkg::ST_SAMPLE;
  assign chan_ext = {1'b0, m_axis_tdata[mcd_pkg::SAMPLE_W +: mcd_pkg::CHAN_W]};

  // error results carry no sample and no channel
  `MCD_ASSERT_IMP(a_err_payload_zero, clk_i, rst_ni, m_axis_tvalid && is_error,
    m_axis_tdata[mcd_pkg::SAMPLE_W + mcd_pkg::CHAN_W - 1:0] == '0)

  // nothing follows a delivered error
  `MCD_ASSERT_NXT(a_halt_after_err, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tready && is_error, !m_axis_tvalid)

  // sample channels stay within both banks
  `MCD_ASSERT_IMP(a_chan_range, clk_i, rst_ni, m_axis_tvalid && !is_error,
    chan_ext < CHAN_LIMIT)

  // a stalled result holds
  `MCD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind multiplexed_channel_deframer mcd_checker #(
  .CHANNELS (CHANNELS)
) u_mcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
